>>> rtl/blpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blpt_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PHASE_RATE   = 3'd0;
    localparam logic [2:0] REG_DECAY_RATE   = 3'd1;
    localparam logic [2:0] REG_CHARGE_GAIN  = 3'd2;
    localparam logic [2:0] REG_INITIAL_REAL = 3'd3;
    localparam logic [2:0] REG_INITIAL_IMAG = 3'd4;
    localparam logic [2:0] REG_INITIAL_TIME = 3'd5;

    localparam int EXP_N    = 45;
    localparam int ATAN_N   = 41;
    localparam int GUARD    = 13;
    localparam logic [63:0] CORDIC_K_Q31 = 64'd1304065748;
    localparam logic [63:0] ONE62 = 64'h4000_0000_0000_0000;

    // Error flag bits
    localparam int FLAG_BACK = 0;
    localparam int FLAG_SAT  = 1;

    // Queue entry passed from the front part to the back part
    typedef struct packed {
        logic        back;
        logic [31:0] ang;
        logic [44:0] x;
        logic        zero;
        logic [15:0] charge;
    } blpt_job_t;

    // Rounded Q2.62 product: (a*b + 2^61) >> 62
    function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b + (128'd1 << 61);
        return p[125:62];
    endfunction

    // exp(-2^(b-40)) in Q2.62, worked out at elaboration only
    function automatic logic [63:0] exp_entry(input int b);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] y3;
        logic [63:0] e;
        int          bb;
        bb = (b <= 24) ? b : 24;
        y  = 64'd1 << (bb + 22);
        y2 = mul62(y, y);
        y3 = mul62(y2, y);
        e  = ONE62 - y + (y2 >> 1) - (y3 / 64'd6);
        // Square upward for the coarse entries
        for (int k = 25; k <= b; k++) begin
            e = mul62(e, e);
        end
        return e;
    endfunction

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t [0:30];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001};
        if (i > 30) begin
            return 32'd0;
        end
        return t[i];
    endfunction

endpackage

`default_nettype wire

>>> rtl/beam_loading_phasor_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// Beam-loading phasor tracker.
// Input channel (in_valid / in_stall): one beat per time-sorted event, with
// arrival_time and charge (zero charge marks a feedback point).
// Output channel (out_valid / out_stall): one beat per event with the new
// phasor, the beam kick and the error flags.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): write
// registers only while the block is idle; writes to the initial values load
// the phasor and the last time at once.
// The front forms dt and the two half products and passes the job through
// the queue; the back part then forms the decay product (one exponent bit
// per cycle when the bit is clear, four partial products for a set bit),
// scales, runs min(CORDIC_STAGES, ATAN_N) rotation steps and updates. The
// serial back part takes a new event only once it is through with the last
// one; the front works on the next event meanwhile.
// Reset clears the rate and gain registers, the phasor and the last time to zero.
// A stalled result holds on the outputs, and the back part waits; the front
// and a two-entry queue keep taking events until they fill.
module beam_loading_phasor_tracker #(
    parameter int TIME_BITS     = 48,
    parameter int VOLT_BITS     = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [TIME_BITS-1:0] arrival_time,
    input  wire logic signed [15:0]   charge,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [31:0]        vbeam_real,
    output logic signed [31:0]        vbeam_imag,
    output logic signed [31:0]        beam_kick,
    output logic [1:0]                error_flags,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [47:0]          cfg_data
);
    import blpt_pkg::*;

    logic [31:0]        phase_rate_reg;
    logic [31:0]        decay_rate_reg;
    logic signed [31:0] charge_gain_reg;
    logic               cfg_wr;
    logic               fr_valid;
    logic               fr_ready;
    blpt_job_t          fr_job;
    logic               bk_valid;
    logic               bk_ready;
    blpt_job_t          bk_job;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;

    // Hold the rate and gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_rate_reg  <= '0;
            decay_rate_reg  <= '0;
            charge_gain_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                REG_PHASE_RATE:  phase_rate_reg  <= cfg_data[31:0];
                REG_DECAY_RATE:  decay_rate_reg  <= cfg_data[31:0];
                REG_CHARGE_GAIN: charge_gain_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    blpt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .arrival_time(arrival_time), .charge(charge),
        .phase_rate(phase_rate_reg), .decay_rate(decay_rate_reg),
        .time_load(cfg_wr && (cfg_index == REG_INITIAL_TIME)),
        .time_value(TIME_BITS'(cfg_data)),
        .job_valid(fr_valid), .job_ready(fr_ready), .job(fr_job)
    );

    blpt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fr_valid), .wr_ready(fr_ready), .wr_data(fr_job),
        .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_data(bk_job)
    );

    blpt_back #(.VOLT_BITS(VOLT_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bk_valid), .job_ready(bk_ready), .job(bk_job),
        .charge_gain(charge_gain_reg),
        .real_load(cfg_wr && (cfg_index == REG_INITIAL_REAL)),
        .real_value(cfg_data[31:0]),
        .imag_load(cfg_wr && (cfg_index == REG_INITIAL_IMAG)),
        .imag_value(cfg_data[31:0]),
        .out_valid(out_valid), .out_stall(out_stall),
        .vbeam_real(vbeam_real), .vbeam_imag(vbeam_imag),
        .beam_kick(beam_kick), .error_flags(error_flags)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vbeam_real) && $stable(error_flags))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result withdrawn");
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel blocked");

endmodule

`default_nettype wire

>>> rtl/blpt_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Front part: forms dt, the turn angle and the decay exponent for one event.
module blpt_front #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [TIME_BITS-1:0] arrival_time,
    input  wire logic signed [15:0]   charge,
    input  wire logic [31:0]          phase_rate,
    input  wire logic [31:0]          decay_rate,
    input  wire logic                 time_load,
    input  wire logic [TIME_BITS-1:0] time_value,
    output logic                      job_valid,
    input  wire logic                 job_ready,
    output blpt_pkg::blpt_job_t       job
);
    import blpt_pkg::*;

    localparam int DW = (TIME_BITS > 64) ? 64 : TIME_BITS;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_MHI, S_OUT} state_t;

    state_t               state_reg;
    logic [TIME_BITS-1:0] last_reg;
    logic [DW-1:0]        dt_reg;
    logic                 back_reg;
    logic [15:0]          charge_reg;
    logic [31:0]          ang_reg;
    logic [44:0]          x_reg;
    logic                 zero_reg;
    logic [39:0]          ph_lo_reg;
    logic [63:0]          dc_lo_reg;

    logic [63:0] dt64;
    logic [31:0] mul_a;
    logic [63:0] ph_part;
    logic [63:0] dc_part;
    logic [31:0] ang_full;
    logic [95:0] dc_full;
    logic        dc_big;

    assign in_stall = (state_reg != S_IDLE) || time_load;
    assign job_valid = (state_reg == S_OUT);
    assign job = '{back: back_reg, ang: ang_reg, x: x_reg, zero: zero_reg,
                   charge: charge_reg};

    // Form the phase and decay products of dt, low half then high half
    always_comb
    begin
        dt64     = 64'(dt_reg);
        mul_a    = (state_reg == S_MUL) ? dt64[31:0] : dt64[63:32];
        ph_part  = {32'd0, mul_a} * {32'd0, phase_rate};
        dc_part  = {32'd0, mul_a} * {32'd0, decay_rate};
        ang_full = ph_lo_reg[39:8] + {ph_part[7:0], 24'd0};
        dc_full  = {32'd0, dc_lo_reg} + {dc_part, 32'd0};
        dc_big   = |dc_full[95:EXP_N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (time_load)
                    begin
                        last_reg <= time_value;
                    end
                    else if (in_valid)
                    begin
                        // Clamp a backward step to zero
                        back_reg   <= (arrival_time < last_reg);
                        dt_reg     <= (arrival_time < last_reg) ? '0 :
                                      DW'(arrival_time - last_reg);
                        charge_reg <= charge;
                        last_reg   <= arrival_time;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    ph_lo_reg <= ph_part[39:0];
                    dc_lo_reg <= dc_part;
                    state_reg <= S_MHI;
                end
                S_MHI:
                begin
                    ang_reg   <= ang_full;
                    x_reg     <= dc_full[44:0];
                    zero_reg  <= dc_big;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (job_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> in_stall)
        else $error("job offered while front accepts");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |=> (state_reg == S_MHI))
        else $error("multiply step skipped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !time_load) |=> (state_reg == S_MUL))
        else $error("accepted beat lost");

endmodule

`default_nettype wire

>>> rtl/blpt_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue between the front and back parts.
module blpt_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire blpt_pkg::blpt_job_t wr_data,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output blpt_pkg::blpt_job_t      rd_data
);
    import blpt_pkg::*;

    blpt_job_t   mem_reg [0:1];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;

    logic do_wr;
    logic do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (wp_reg == rp_reg))
        else $error("empty queue with split pointers");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> (wp_reg == rp_reg))
        else $error("full queue with split pointers");

endmodule

`default_nettype wire

>>> rtl/blpt_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Back part: decay product, scaling, CORDIC rotation and update of the phasor.
module blpt_back #(
    parameter int VOLT_BITS     = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     job_valid,
    output logic                          job_ready,
    input  wire blpt_pkg::blpt_job_t      job,
    input  wire logic signed [31:0]       charge_gain,
    input  wire logic                     real_load,
    input  wire logic signed [31:0]       real_value,
    input  wire logic                     imag_load,
    input  wire logic signed [31:0]       imag_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [31:0]            vbeam_real,
    output logic signed [31:0]            vbeam_imag,
    output logic signed [31:0]            beam_kick,
    output logic [1:0]                    error_flags
);
    import blpt_pkg::*;

    localparam int NST = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int WW  = VOLT_BITS + GUARD + 8;
    localparam int SW  = $clog2(EXP_N + 1);
    localparam int IW  = $clog2(NST + 1);
    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VOLT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

    typedef enum logic [2:0] {S_IDLE, S_EXP, S_SCALE, S_PROD, S_ROT, S_FIN, S_OUT}
        state_t;

    state_t                 state_reg;
    logic signed [VOLT_BITS-1:0] pr_reg;
    logic signed [VOLT_BITS-1:0] pi_reg;
    logic [SW-1:0]          bit_reg;
    logic [1:0]             sub_reg;
    logic [127:0]           acc_reg;
    logic [IW-1:0]          it_reg;
    logic [63:0]            d_reg;
    logic [31:0]            m_reg;
    logic [44:0]            x_reg;
    logic [1:0]             quad_reg;
    logic signed [32:0]     z_reg;
    logic signed [WW-1:0]   cx_reg;
    logic signed [WW-1:0]   cy_reg;
    logic signed [63:0]     add_reg;
    logic                   back_reg;
    logic                   sat_reg;
    logic signed [31:0]     or_reg;
    logic signed [31:0]     oi_reg;
    logic signed [31:0]     ok_reg;
    logic [1:0]             of_reg;

    logic [63:0] rom_word;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pp;
    logic [127:0] pp_sh;
    logic [127:0] acc_next;
    logic [63:0] dq31;
    logic [63:0] mfull;
    logic signed [WW-1:0] sx;
    logic signed [WW-1:0] sy;
    logic signed [WW-1:0] rx;
    logic signed [WW-1:0] ry;
    logic [31:0] atan_w;
    logic signed [63:0] vr_raw;
    logic signed [63:0] vi_raw;
    logic signed [63:0] vr_s;
    logic signed [63:0] vi_s;
    logic signed [63:0] k_raw;
    logic signed [63:0] k_s;
    logic               fsat;
    logic [31:0]        r30;
    logic [1:0]         q0;

    assign job_ready  = (state_reg == S_IDLE) && !real_load && !imag_load;
    assign out_valid  = (state_reg == S_OUT);
    assign vbeam_real = or_reg;
    assign vbeam_imag = oi_reg;
    assign beam_kick  = ok_reg;
    assign error_flags = of_reg;

    // Read the exp ROM and the arctangent table
    always_comb
    begin
        rom_word = '0;
        for (int b = 0; b < EXP_N; b++)
        begin
            if (bit_reg == SW'(b))
            begin
                rom_word = exp_entry(b);
            end
        end
        atan_w = '0;
        for (int i = 0; i < NST; i++)
        begin
            if (it_reg == IW'(i))
            begin
                atan_w = atan_turn(i);
            end
        end
    end

    // One 32x32 partial product of the decay multiply per cycle
    always_comb
    begin
        ma = sub_reg[1] ? d_reg[63:32] : d_reg[31:0];
        mb = sub_reg[0] ? rom_word[63:32] : rom_word[31:0];
        pp = {32'd0, ma} * {32'd0, mb};
        unique case (sub_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        acc_next = ((sub_reg == 2'd0) ? (128'd1 << 61) : acc_reg) + pp_sh;
    end

    // Scale constants and micro-rotation
    always_comb
    begin
        dq31  = (d_reg + (64'd1 << 30)) >> 31;
        mfull = {32'd0, dq31[31:0]} * {32'd0, CORDIC_K_Q31[31:0]} + (64'd1 << 30);
        sx    = cx_reg >>> it_reg;
        sy    = cy_reg >>> it_reg;
        rx    = (z_reg >= 0) ? cx_reg - sy : cx_reg + sy;
        ry    = (z_reg >= 0) ? cy_reg + sx : cy_reg - sx;
        r30   = {2'b00, job.ang[29:0]};
        q0    = job.ang[31:30];
    end

    // Round, add and saturate
    always_comb
    begin
        fsat   = 1'b0;
        vr_raw = 64'((cx_reg + (WW'(1) <<< (GUARD - 1))) >>> GUARD) + add_reg;
        vi_raw = 64'((cy_reg + (WW'(1) <<< (GUARD - 1))) >>> GUARD);
        vr_s = vr_raw;
        if (vr_raw > VMAX) begin vr_s = VMAX; fsat = 1'b1; end
        else if (vr_raw < VMIN) begin vr_s = VMIN; fsat = 1'b1; end
        vi_s = vi_raw;
        if (vi_raw > VMAX) begin vi_s = VMAX; fsat = 1'b1; end
        else if (vi_raw < VMIN) begin vi_s = VMIN; fsat = 1'b1; end
        k_raw = vr_s - (add_reg >>> 1);
        k_s = k_raw;
        if (k_raw > VMAX) begin k_s = VMAX; fsat = 1'b1; end
        else if (k_raw < VMIN) begin k_s = VMIN; fsat = 1'b1; end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] a_raw;
        logic signed [WW-1:0] xs;
        logic signed [WW-1:0] ys;
        logic signed [WW-1:0] ph;
        logic signed [WW-1:0] pl;
        logic signed [WW-1:0] qh;
        logic signed [WW-1:0] ql;
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pr_reg    <= '0;
            pi_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (real_load)
                    begin
                        pr_reg <= VOLT_BITS'(real_value);
                    end
                    if (imag_load)
                    begin
                        pi_reg <= VOLT_BITS'(imag_value);
                    end
                    if (job_valid && job_ready)
                    begin
                        // Charge term, quadrant split
                        a_raw = -((64'($signed(job.charge)) * 64'(charge_gain)) >>> 15);
                        sat_reg <= 1'b0;
                        if (a_raw > VMAX)
                        begin
                            add_reg <= VMAX;
                            sat_reg <= 1'b1;
                        end
                        else if (a_raw < VMIN)
                        begin
                            add_reg <= VMIN;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            add_reg <= a_raw;
                        end
                        back_reg <= job.back;
                        if (r30 >= 32'h2000_0000)
                        begin
                            quad_reg <= q0 + 2'd1;
                            z_reg <= 33'(signed'({1'b0, r30})) - 33'sh4000_0000;
                        end
                        else
                        begin
                            quad_reg <= q0;
                            z_reg <= signed'({1'b0, r30});
                        end
                        x_reg   <= job.x;
                        d_reg   <= job.zero ? 64'd0 : ONE62;
                        bit_reg <= '0;
                        sub_reg <= '0;
                        state_reg <= S_EXP;
                    end
                end
                S_EXP:
                begin
                    // One clear bit per cycle; four products for a set bit
                    if (x_reg[bit_reg[5:0]] && (sub_reg != 2'd3))
                    begin
                        acc_reg <= acc_next;
                        sub_reg <= sub_reg + 2'd1;
                    end
                    else
                    begin
                        if (x_reg[bit_reg[5:0]])
                        begin
                            d_reg   <= acc_next[125:62];
                            sub_reg <= 2'd0;
                        end
                        if (bit_reg == SW'(EXP_N - 1))
                        begin
                            state_reg <= S_SCALE;
                        end
                        bit_reg <= bit_reg + SW'(1);
                    end
                end
                S_SCALE:
                begin
                    m_reg <= mfull[62:31];
                    state_reg <= S_PROD;
                end
                S_PROD:
                begin
                    // Scale by m with guard bits, then the quarter turn
                    ph = WW'((64'(pr_reg) * $signed({48'd0, m_reg[31:16]})) >>> 2);
                    pl = WW'((64'(pr_reg) * $signed({48'd0, m_reg[15:0]})) >>> 18);
                    qh = WW'((64'(pi_reg) * $signed({48'd0, m_reg[31:16]})) >>> 2);
                    ql = WW'((64'(pi_reg) * $signed({48'd0, m_reg[15:0]})) >>> 18);
                    xs = ph + pl;
                    ys = qh + ql;
                    unique case (quad_reg)
                        2'd0: begin cx_reg <= xs;  cy_reg <= ys;  end
                        2'd1: begin cx_reg <= -ys; cy_reg <= xs;  end
                        2'd2: begin cx_reg <= -xs; cy_reg <= -ys; end
                        default: begin cx_reg <= ys; cy_reg <= -xs; end
                    endcase
                    it_reg <= '0;
                    state_reg <= (NST == 0) ? S_FIN : S_ROT;
                end
                S_ROT:
                begin
                    cx_reg <= rx;
                    cy_reg <= ry;
                    z_reg  <= (z_reg >= 0) ? z_reg - 33'(signed'({1'b0, atan_w}))
                                           : z_reg + 33'(signed'({1'b0, atan_w}));
                    if (it_reg == IW'(NST - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    it_reg <= it_reg + IW'(1);
                end
                S_FIN:
                begin
                    pr_reg <= VOLT_BITS'(vr_s);
                    pi_reg <= VOLT_BITS'(vi_s);
                    or_reg <= 32'(vr_s);
                    oi_reg <= 32'(vi_s);
                    ok_reg <= 32'(k_s);
                    of_reg <= {sat_reg | fsat, back_reg};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> out_valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |-> $past(state_reg == S_EXP))
        else $error("decay sweep cut short");

endmodule

`default_nettype wire

>>> bench/beam_loading_phasor_tracker_tb.sv
`timescale 1ns / 1ps

module beam_loading_phasor_tracker_tb;
    import blpt_pkg::*;

    localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
    localparam int STAGES = 24;
    localparam int SETTLE = 120;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [31:0] kick;
        logic [1:0]  flags;
    } phasor_beat_t;

    // Scoreboard: phasor predictor plus the queue of expected result beats
    class phasor_scoreboard;
        longint unsigned exp_table [EXP_N];
        longint          atan_tab [ATAN_N];
        longint unsigned prate, drate, t_last;
        longint          gain, ph_re, ph_im;
        bit [1:0]        fl;
        phasor_beat_t    pending_q [$];
        int              errors;

        function new();
            longint unsigned y, y2, y3;
            atan_tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
                64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
                64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30,
                64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003,
                64'h00000001, 64'h00000001, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
            // Build exp(-2^(b-40)): cubic series low, repeated squares high
            for (int b = 0; b < EXP_N; b++) begin
                if (b <= 24) begin
                    y  = 64'd1 << (b + 22);
                    y2 = qmul(y, y);
                    y3 = qmul(y2, y);
                    exp_table[b] = ONE62 - y + y2 / 2 - y3 / 6;
                end else begin
                    exp_table[b] = qmul(exp_table[b-1], exp_table[b-1]);
                end
            end
            prate = 0; drate = 0; gain = 0; ph_re = 0; ph_im = 0; t_last = 0;
            errors = 0;
        endfunction

        function longint unsigned qmul(longint unsigned a, longint unsigned b);
            bit [127:0] p;
            p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
            return p[125:62];
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) begin
                fl[FLAG_SAT] = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                fl[FLAG_SAT] = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] data);
            case (idx)
                REG_PHASE_RATE:   prate = data[31:0];
                REG_DECAY_RATE:   drate = data[31:0];
                REG_CHARGE_GAIN:  gain = longint'($signed(data[31:0]));
                REG_INITIAL_REAL: ph_re = longint'($signed(data[31:0]));
                REG_INITIAL_IMAG: ph_im = longint'($signed(data[31:0]));
                REG_INITIAL_TIME: t_last = data;
                default: ;
            endcase
        endfunction

        // Decay factor exp(-dt*rate*2^-40) in Q2.62
        function longint unsigned decay_of(longint unsigned dt);
            longint unsigned hi, plo, xx, d;
            hi = dt >> 32;
            plo = (dt & MASK32) * drate;
            if (hi != 0 && drate > 8191 / hi) return 0;
            xx = ((hi * drate) << 32) + plo;
            if (xx < plo) return 0;
            if ((xx >> EXP_N) != 0) return 0;
            d = ONE62;
            for (int b = 0; b < EXP_N; b++)
                if (xx[b]) d = qmul(d, exp_table[b]);
            return d;
        endfunction

        // Advance the phasor by one event and queue the expected beat
        function void note_event(logic [47:0] t, logic signed [15:0] q);
            longint unsigned dt, ang, r, dq, m, mh, ml;
            longint z, x, y, tmp, add, vr, vi, kick, xs, ys, qq;
            int quad;
            phasor_beat_t e;
            fl = 2'b00;
            qq = longint'(q);
            if (t < t_last) begin
                dt = 0;
                fl[FLAG_BACK] = 1'b1;
            end else begin
                dt = t - t_last;
            end
            add = clamp32(-((qq * gain) >>> 15));
            ang = ((dt * prate) >> 8) & MASK32;
            quad = int'(ang >> 30);
            r = ang & 64'h3FFF_FFFF;
            if (r >= 64'h2000_0000) begin
                quad = (quad + 1) & 3;
                z = longint'(r) - 64'sh4000_0000;
            end else begin
                z = longint'(r);
            end
            dq = (decay_of(dt) + (64'd1 << 30)) >> 31;
            m = (dq * CORDIC_K_Q31 + (64'd1 << 30)) >> 31;
            mh = m >> 16;
            ml = m & 64'hFFFF;
            x = ((ph_re * longint'(mh)) >>> 2) + ((ph_re * longint'(ml)) >>> 18);
            y = ((ph_im * longint'(mh)) >>> 2) + ((ph_im * longint'(ml)) >>> 18);
            // Coarse quarter turns, then micro-rotations
            if (quad == 1) begin
                tmp = x; x = -y; y = tmp;
            end else if (quad == 2) begin
                x = -x; y = -y;
            end else if (quad == 3) begin
                tmp = x; x = y; y = -tmp;
            end
            for (int i = 0; i < STAGES && i < ATAN_N; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys; y = y + xs; z = z - atan_tab[i];
                end else begin
                    x = x + ys; y = y - xs; z = z + atan_tab[i];
                end
            end
            vr = (x + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
            vi = (y + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
            vr = clamp32(vr + add);
            vi = clamp32(vi);
            kick = clamp32(vr - (add >>> 1));
            ph_re = vr;
            ph_im = vi;
            t_last = t;
            e.re = vr[31:0];
            e.im = vi[31:0];
            e.kick = kick[31:0];
            e.flags = fl;
            pending_q.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_beat(phasor_beat_t got);
            phasor_beat_t w;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat", got.re, 32'd0);
                return;
            end
            w = pending_q.pop_front();
            if (got.re !== w.re) report_mismatch("vbeam_real", got.re, w.re);
            if (got.im !== w.im) report_mismatch("vbeam_imag", got.im, w.im);
            if (got.kick !== w.kick) report_mismatch("beam_kick", got.kick, w.kick);
            if (got.flags !== w.flags)
                report_mismatch("error_flags", 32'(got.flags), 32'(w.flags));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [47:0] arrival_time = '0;
    logic signed [15:0] charge = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic signed [31:0] vbeam_real, vbeam_imag, beam_kick;
    logic [1:0]  error_flags;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    phasor_scoreboard sb = new();
    logic [47:0] now_t;

    beam_loading_phasor_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .arrival_time(arrival_time), .charge(charge),
        .out_valid(out_valid), .out_stall(out_stall),
        .vbeam_real(vbeam_real), .vbeam_imag(vbeam_imag),
        .beam_kick(beam_kick), .error_flags(error_flags),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    // Receiver stall pattern
    initial begin
        int g;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            out_stall = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            g = pick_gap();
            if (g > 0) begin
                out_stall = 1'b1;
                repeat (g) @(negedge clk);
            end
        end
    end

    // Collect result beats
    always @(posedge clk) begin
        phasor_beat_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.re = vbeam_real;
            got.im = vbeam_imag;
            got.kick = beam_kick;
            got.flags = error_flags;
            sb.check_beat(got);
        end
    end

    task write_cfg(logic [2:0] idx, logic [47:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task send_event(logic [47:0] t, logic signed [15:0] q);
        int g;
        arrival_time = t;
        charge = q;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_event(t, q);
        now_t = t;
        @(negedge clk);
        g = pick_gap();
        if (g > 0) begin
            in_valid = 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    // Drain all expected beats, then let the pipeline settle
    task drain();
        in_valid = 1'b0;
        while (sb.pending_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    function logic [31:0] pick_word(int kind);
        case (kind)
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function logic [47:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return now_t - $urandom_range(1, 5000);
        if (r < 10) return 48'({$urandom(), $urandom()});
        if (r < 14) return now_t;
        if (r < 75) return now_t + $urandom_range(1, 2000);
        return now_t + {16'd0, $urandom()};
    endfunction

    function logic signed [15:0] next_charge();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'sd0;
        if (r == 2) return 16'sh8000;
        if (r == 3) return 16'sh7FFF;
        return 16'($urandom());
    endfunction

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        now_t = '0;

        // Directed: all registers at reset
        send_event(48'd0, 16'sd0);
        send_event(48'd500, 16'sh7FFF);
        drain();

        // Directed: strong gain, some rotation, light decay
        write_cfg(REG_PHASE_RATE, 48'h0000_1234_5678);
        write_cfg(REG_DECAY_RATE, 48'h0000_0010_0000);
        write_cfg(REG_CHARGE_GAIN, 48'h0000_7FFF_FFFF);
        write_cfg(REG_INITIAL_REAL, 48'h0000_4000_0000);
        write_cfg(REG_INITIAL_IMAG, 48'h0000_C000_0000);
        write_cfg(REG_INITIAL_TIME, 48'd1000);
        write_cfg(3'd6, 48'hFFFF_FFFF_FFFF);
        write_cfg(3'd7, 48'h5555_AAAA_5555);
        send_event(48'd1000, 16'sh8000);
        send_event(48'd1100, 16'sh7FFF);
        send_event(48'd1100, 16'sd0);
        send_event(48'd900, 16'sd1);
        send_event(48'd5000, 16'shFFFF);
        send_event(48'hFFFF_FFFF_FFFF, 16'sd0);
        send_event(48'hFFFF_FFFF_FFFE, 16'sh4000);
        send_event(48'd0, 16'sd0);
        drain();

        // Directed: saturate from a phasor at full scale
        write_cfg(REG_PHASE_RATE, 48'h0);
        write_cfg(REG_DECAY_RATE, 48'h0);
        write_cfg(REG_CHARGE_GAIN, 48'h0000_8000_0000);
        write_cfg(REG_INITIAL_REAL, 48'h0000_7FFF_FFFF);
        write_cfg(REG_INITIAL_IMAG, 48'h0000_8000_0000);
        write_cfg(REG_INITIAL_TIME, 48'h0);
        send_event(48'd10, 16'sh8000);
        send_event(48'd20, 16'sh7FFF);
        send_event(48'd30, 16'sh8000);
        drain();
        write_cfg(REG_CHARGE_GAIN, 48'h0000_7FFF_FFFF);
        send_event(48'd40, 16'sh8000);
        send_event(48'd50, 16'sh7FFF);
        drain();

        // Random phases
        for (int ph = 0; ph < 12; ph++) begin
            int dk;
            dk = $urandom_range(0, 9);
            write_cfg(REG_PHASE_RATE, {16'($urandom()), pick_word($urandom_range(0, 5))});
            if (dk < 2) write_cfg(REG_DECAY_RATE, {16'($urandom()), pick_word(dk)});
            else write_cfg(REG_DECAY_RATE, {16'($urandom()), 32'($urandom_range(0, 1 << 26))});
            write_cfg(REG_CHARGE_GAIN, {16'($urandom()), pick_word($urandom_range(0, 6))});
            write_cfg(REG_INITIAL_REAL, {16'($urandom()), pick_word($urandom_range(0, 6))});
            write_cfg(REG_INITIAL_IMAG, {16'($urandom()), pick_word($urandom_range(0, 6))});
            if (ph == 3) write_cfg(REG_INITIAL_TIME, 48'hFFFF_FFFF_F000);
            else write_cfg(REG_INITIAL_TIME, {16'($urandom()), 32'($urandom())});
            for (int k = 0; k < 44; k++) begin
                if (ph == 5 && k == 20) drain();
                send_event(next_time(), next_charge());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
